### src/atilt_pkg.sv
// ----------------------------------------------------------------------------
// atilt_pkg
// Shared constants and tables for the accelerometer tilt angle pipeline.
// ----------------------------------------------------------------------------
package atilt_pkg;

	localparam int SAMPLE_BITS_DEF = 16;

	// Orientation codes
	localparam logic [1:0] ORIENT_0   = 2'd0;
	localparam logic [1:0] ORIENT_90  = 2'd1;
	localparam logic [1:0] ORIENT_180 = 2'd2;
	localparam logic [1:0] ORIENT_270 = 2'd3;
	localparam logic [1:0] ORIENT_RESET = ORIENT_90;

	// Normalized sum lives in a 62-bit word, root has 31 bits
	localparam int NORM_W      = 62;
	localparam int NORM_STEPS  = 5;
	localparam int ROOT_STEPS  = 31;
	localparam int CORDIC_STEPS = 20;

	// Angle accumulator in 2^-16 degree
	localparam int ANGLE_ACC_W = 25;
	localparam int ANGLE_W     = 15;
	localparam int ANGLE_LIMIT = 11520;

	// squares, sum, normalize, root, cordic, round
	localparam int LANE_STAGES = 1 + 1 + NORM_STEPS + ROOT_STEPS + CORDIC_STEPS + 1;

	// round(atan(2^-i) in degrees * 65536)
	function automatic logic [ANGLE_ACC_W-1:0] atan_step(input int unsigned i);
		logic [ANGLE_ACC_W-1:0] v;
		case (i)
			0:  v = 25'd2949120;
			1:  v = 25'd1740967;
			2:  v = 25'd919879;
			3:  v = 25'd466945;
			4:  v = 25'd234379;
			5:  v = 25'd117304;
			6:  v = 25'd58666;
			7:  v = 25'd29335;
			8:  v = 25'd14668;
			9:  v = 25'd7334;
			10: v = 25'd3667;
			11: v = 25'd1833;
			12: v = 25'd917;
			13: v = 25'd458;
			14: v = 25'd229;
			15: v = 25'd115;
			16: v = 25'd57;
			17: v = 25'd29;
			18: v = 25'd14;
			19: v = 25'd7;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

### src/atilt_lane.sv
// ----------------------------------------------------------------------------
// atilt_lane
// One tilt angle: -atan(n / sqrt(a^2 + b^2)) in 1/128 degree. Squares, a
// staged normalize, a pipelined bitwise square root and a pipelined vectoring
// CORDIC, one step per stage. Advances when en is high.
// ----------------------------------------------------------------------------
module atilt_lane
	import atilt_pkg::*;
#(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      en,
	input  logic signed [SAMPLE_BITS:0] n,
	input  logic signed [SAMPLE_BITS:0] a,
	input  logic signed [SAMPLE_BITS:0] b,
	output logic signed [ANGLE_W-1:0] angle,
	output logic                      bad
);

	localparam int NW = SAMPLE_BITS + 1;
	localparam int CW = SAMPLE_BITS + 34;

	// Stage 1: squares
	logic signed [2*NW-1:0] sqa_s1, sqb_s1;
	logic signed [NW-1:0]   n_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			sqa_s1 <= a * a;
			sqb_s1 <= b * b;
			n_s1   <= n;
		end
	end

	// Stage 2: sum of squares, zero check
	logic [NORM_W-1:0]   sum_s2;
	logic signed [CW-1:0] n_s2;
	logic                bad_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s2 <= NORM_W'(unsigned'(sqa_s1)) + NORM_W'(unsigned'(sqb_s1));
			n_s2   <= CW'(n_s1);
			bad_s2 <= (sqa_s1 == '0) && (sqb_s1 == '0);
		end
	end

	// Normalize: shift sum by 4^s and n by 2^s while the sum stays below 2^62
	logic [NORM_W-1:0]   nm_sum_s [NORM_STEPS];
	logic signed [CW-1:0] nm_n_s   [NORM_STEPS];
	logic                nm_bad_s [NORM_STEPS];

	for (genvar j = 0; j < NORM_STEPS; j++) begin : g_norm
		localparam int S = 16 >> j;
		logic [NORM_W-1:0]   sum_in;
		logic signed [CW-1:0] n_in;
		logic                bad_in;
		if (j == 0) begin : g_head
			assign sum_in = sum_s2;
			assign n_in   = n_s2;
			assign bad_in = bad_s2;
		end else begin : g_body
			assign sum_in = nm_sum_s[j-1];
			assign n_in   = nm_n_s[j-1];
			assign bad_in = nm_bad_s[j-1];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				if (sum_in[NORM_W-1 -: 2*S] == '0) begin
					nm_sum_s[j] <= sum_in << (2*S);
					nm_n_s[j]   <= n_in <<< S;
				end else begin
					nm_sum_s[j] <= sum_in;
					nm_n_s[j]   <= n_in;
				end
				nm_bad_s[j] <= bad_in;
			end
		end
	end

	// Square root, one result bit per stage
	logic [NORM_W-1:0]   rt_rem_s [ROOT_STEPS];
	logic [NORM_W-1:0]   rt_res_s [ROOT_STEPS];
	logic signed [CW-1:0] rt_y_s   [ROOT_STEPS];
	logic                rt_bad_s [ROOT_STEPS];

	for (genvar j = 0; j < ROOT_STEPS; j++) begin : g_root
		localparam logic [NORM_W-1:0] BIT = NORM_W'(1) << (NORM_W - 2 - 2*j);
		logic [NORM_W-1:0]   rem_in, res_in, trial;
		logic signed [CW-1:0] y_in;
		logic                bad_in;
		if (j == 0) begin : g_head
			assign rem_in = nm_sum_s[NORM_STEPS-1];
			assign res_in = '0;
			assign y_in   = nm_n_s[NORM_STEPS-1];
			assign bad_in = nm_bad_s[NORM_STEPS-1];
		end else begin : g_body
			assign rem_in = rt_rem_s[j-1];
			assign res_in = rt_res_s[j-1];
			assign y_in   = rt_y_s[j-1];
			assign bad_in = rt_bad_s[j-1];
		end
		assign trial = res_in + BIT;
		always_ff @(posedge clk) begin
			if (en) begin
				if (rem_in >= trial) begin
					rt_rem_s[j] <= rem_in - trial;
					rt_res_s[j] <= (res_in >> 1) + BIT;
				end else begin
					rt_rem_s[j] <= rem_in;
					rt_res_s[j] <= res_in >> 1;
				end
				rt_y_s[j]   <= y_in;
				rt_bad_s[j] <= bad_in;
			end
		end
	end

	// Vectoring CORDIC, one rotation per stage
	logic signed [CW-1:0]          cd_x_s   [CORDIC_STEPS];
	logic signed [CW-1:0]          cd_y_s   [CORDIC_STEPS];
	logic signed [ANGLE_ACC_W-1:0] cd_z_s   [CORDIC_STEPS];
	logic                          cd_bad_s [CORDIC_STEPS];

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
		localparam logic signed [ANGLE_ACC_W-1:0] ATAN = atan_step(i);
		logic signed [CW-1:0]          x_in, y_in, xs, ys;
		logic signed [ANGLE_ACC_W-1:0] z_in;
		logic                          bad_in;
		if (i == 0) begin : g_head
			assign x_in   = CW'(rt_res_s[ROOT_STEPS-1][ROOT_STEPS-1:0]);
			assign y_in   = rt_y_s[ROOT_STEPS-1];
			assign z_in   = '0;
			assign bad_in = rt_bad_s[ROOT_STEPS-1];
		end else begin : g_body
			assign x_in   = cd_x_s[i-1];
			assign y_in   = cd_y_s[i-1];
			assign z_in   = cd_z_s[i-1];
			assign bad_in = cd_bad_s[i-1];
		end
		assign xs = x_in >>> i;
		assign ys = y_in >>> i;
		always_ff @(posedge clk) begin
			if (en) begin
				if (!y_in[CW-1]) begin
					cd_x_s[i] <= x_in + ys;
					cd_y_s[i] <= y_in - xs;
					cd_z_s[i] <= z_in + ATAN;
				end else begin
					cd_x_s[i] <= x_in - ys;
					cd_y_s[i] <= y_in + xs;
					cd_z_s[i] <= z_in - ATAN;
				end
				cd_bad_s[i] <= bad_in;
			end
		end
	end

	// Round to 1/128 degree, negate, saturate
	logic signed [ANGLE_ACC_W:0] z_rnd, z_neg;
	logic signed [ANGLE_W-1:0]   angle_s;
	logic                        bad_s;

	assign z_rnd = (ANGLE_ACC_W+1)'(cd_z_s[CORDIC_STEPS-1]) + (ANGLE_ACC_W+1)'(256);
	assign z_neg = -(z_rnd >>> 9);

	always_ff @(posedge clk) begin
		if (en) begin
			if (cd_bad_s[CORDIC_STEPS-1]) begin
				angle_s <= '0;
			end else if (z_neg > (ANGLE_ACC_W+1)'(ANGLE_LIMIT)) begin
				angle_s <= ANGLE_W'(ANGLE_LIMIT);
			end else if (z_neg < -(ANGLE_ACC_W+1)'(ANGLE_LIMIT)) begin
				angle_s <= -ANGLE_W'(ANGLE_LIMIT);
			end else begin
				angle_s <= z_neg[ANGLE_W-1:0];
			end
			bad_s <= cd_bad_s[CORDIC_STEPS-1];
		end
	end

	assign angle = angle_s;
	assign bad   = bad_s;

endmodule

### src/accelerometer_tilt_angles.sv
// ----------------------------------------------------------------------------
// accelerometer_tilt_angles
// Pitch and roll from a three-axis accelerometer sample, 1/128 degree units.
// ----------------------------------------------------------------------------
// Takes one sample per clock while in_stall is low and returns one
// pitch/roll transaction per sample, in order. The pipeline is one rotation
// stage, then two identical lanes side by side, each with a squaring stage,
// a sum stage, five normalize stages, a 31-stage bitwise square root, a
// 20-stage CORDIC and a rounding stage. The whole pipeline holds while the
// output transaction is stalled, so in_stall follows out_stall only when the
// last stage is full. Write orientation only while the pipeline is empty.
module accelerometer_tilt_angles
	import atilt_pkg::*;
#(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [1:0]                   cfg_wr_data,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic signed [SAMPLE_BITS-1:0] accel_x,
	input  logic signed [SAMPLE_BITS-1:0] accel_y,
	input  logic signed [SAMPLE_BITS-1:0] accel_z,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic signed [ANGLE_W-1:0]    pitch_angle,
	output logic signed [ANGLE_W-1:0]    roll_angle,
	output logic                         pitch_invalid,
	output logic                         roll_invalid
);

	localparam int NW = SAMPLE_BITS + 1;

	logic [1:0] orientation_q;
	logic       en;
	logic       vld_q [LANE_STAGES+1];

	// Orientation register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			orientation_q <= ORIENT_RESET;
		end else if (cfg_wr_en) begin
			orientation_q <= cfg_wr_data;
		end
	end

	// Hold everything while the finished transaction waits
	assign en       = !(vld_q[LANE_STAGES] && out_stall);
	assign in_stall = !en;

	// Valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= LANE_STAGES; i++) vld_q[i] <= 1'b0;
		end else if (en) begin
			vld_q[0] <= in_valid;
			for (int i = 1; i <= LANE_STAGES; i++) vld_q[i] <= vld_q[i-1];
		end
	end

	// Rotate X/Y by the screen orientation, one bit wider for negation
	logic signed [NW-1:0] ex, ey, tx, ty;
	logic signed [NW-1:0] tx_s1, ty_s1, tz_s1;

	assign ex = NW'(accel_x);
	assign ey = NW'(accel_y);

	always_comb begin
		case (orientation_q)
			ORIENT_0:   begin tx = ex;  ty = ey;  end
			ORIENT_90:  begin tx = -ey; ty = ex;  end
			ORIENT_180: begin tx = -ex; ty = -ey; end
			ORIENT_270: begin tx = ey;  ty = -ex; end
			default:    begin tx = ex;  ty = ey;  end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tx_s1 <= tx;
			ty_s1 <= ty;
			tz_s1 <= NW'(accel_z);
		end
	end

	// Pitch from (ty; tx, tz), roll from (tx; ty, tz)
	atilt_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_pitch (
		.clk   (clk),
		.en    (en),
		.n     (ty_s1),
		.a     (tx_s1),
		.b     (tz_s1),
		.angle (pitch_angle),
		.bad   (pitch_invalid)
	);

	atilt_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_roll (
		.clk   (clk),
		.en    (en),
		.n     (tx_s1),
		.a     (ty_s1),
		.b     (tz_s1),
		.angle (roll_angle),
		.bad   (roll_invalid)
	);

	assign out_valid = vld_q[LANE_STAGES];

endmodule

### tb/tb_accelerometer_tilt_angles.sv
// ----------------------------------------------------------------------------
// tb_accelerometer_tilt_angles
// Self-checking bench for the pitch/roll pipeline: a fixed-point predictor
// computes expected angles per sample, a monitor compares each output
// transaction in order, and both sides idle and stall at random by phase.
// ----------------------------------------------------------------------------
module tb_accelerometer_tilt_angles;
	import atilt_pkg::*;

	localparam int SB        = 16;
	localparam int WATCHDOG  = 20000;
	localparam int PIPE_WAIT = LANE_STAGES + 10;

	typedef struct packed {
		logic signed [SB-1:0] x;
		logic signed [SB-1:0] y;
		logic signed [SB-1:0] z;
	} sample_t;

	typedef struct packed {
		logic signed [ANGLE_W-1:0] pitch;
		logic signed [ANGLE_W-1:0] roll;
		logic                      pitch_bad;
		logic                      roll_bad;
	} tilt_t;

	logic clk = 1'b0;
	logic arst_n = 1'b1;
	logic cfg_wr_en = 1'b0;
	logic [1:0] cfg_wr_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [SB-1:0] accel_x = '0, accel_y = '0, accel_z = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [ANGLE_W-1:0] pitch_angle, roll_angle;
	logic pitch_invalid, roll_invalid;

	sample_t sample_q[$];
	tilt_t   angle_q[$];
	logic [1:0] orient = ORIENT_RESET;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_cycles = 0;
	int errors = 0;
	int n_sent = 0;
	int n_checked = 0;
	int n_bad_flags = 0;
	int quiet = 0;

	accelerometer_tilt_angles #(.SAMPLE_BITS(SB)) dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.accel_x(accel_x), .accel_y(accel_y), .accel_z(accel_z),
		.out_valid(out_valid), .out_stall(out_stall),
		.pitch_angle(pitch_angle), .roll_angle(roll_angle),
		.pitch_invalid(pitch_invalid), .roll_invalid(roll_invalid)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// floor shift of a signed value
	function automatic longint fshift(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint int_sqrt(longint unsigned v);
		longint unsigned rem, res, bitv;
		rem = v;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > rem)
			bitv >>= 2;
		while (bitv != 0) begin
			if (rem >= res + bitv) begin
				rem -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return longint'(res);
	endfunction

	// -atan(n / sqrt(a^2 + b^2)) in 1/128 degree via 20-step vectoring CORDIC
	function automatic void tilt_angle(input longint n, input longint a, input longint b,
			output logic signed [ANGLE_W-1:0] ang, output logic bad);
		longint unsigned sum;
		longint scale, xv, yv, zv, xs, ys, r;
		sum = longint'(a * a) + longint'(b * b);
		scale = 1;
		zv = 0;
		if (sum == 0) begin
			ang = '0;
			bad = 1'b1;
			return;
		end
		bad = 1'b0;
		while (sum < (64'd1 << 60)) begin
			sum <<= 2;
			scale *= 2;
		end
		xv = int_sqrt(sum);
		yv = n * scale;
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			xs = fshift(xv, i);
			ys = fshift(yv, i);
			if (yv >= 0) begin
				xv = xv + ys;
				yv = yv - xs;
				zv += longint'(atan_step(i));
			end else begin
				xv = xv - ys;
				yv = yv + xs;
				zv -= longint'(atan_step(i));
			end
		end
		r = -fshift(zv + 256, 9);
		if (r > ANGLE_LIMIT)
			r = ANGLE_LIMIT;
		if (r < -ANGLE_LIMIT)
			r = -ANGLE_LIMIT;
		ang = ANGLE_W'(r);
	endfunction

	function automatic tilt_t predict_tilt(sample_t s, logic [1:0] o);
		tilt_t t;
		longint x, y, tx, ty, tz;
		x = s.x;
		y = s.y;
		tz = s.z;
		case (o)
			ORIENT_90: begin
				tx = -y; ty = x;
			end
			ORIENT_180: begin
				tx = -x; ty = -y;
			end
			ORIENT_270: begin
				tx = y; ty = -x;
			end
			default: begin
				tx = x; ty = y;
			end
		endcase
		tilt_angle(ty, tx, tz, t.pitch, t.pitch_bad);
		tilt_angle(tx, ty, tz, t.roll, t.roll_bad);
		return t;
	endfunction

	// Sampled handshake state at the rising edge
	logic in_stall_s = 1'b0;
	always @(posedge clk)
		in_stall_s <= in_stall;

	// Driver: present pending samples at the falling edge, hold while stalled
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall_s) begin
				n_sent <= n_sent + 1;
			end
			if (!in_valid || !in_stall_s) begin
				if (sample_q.size() > 0 && $urandom_range(99, 0) >= send_idle_pct) begin
					accel_x <= sample_q[0].x;
					accel_y <= sample_q[0].y;
					accel_z <= sample_q[0].z;
					angle_q.push_back(predict_tilt(sample_q[0], orient));
					void'(sample_q.pop_front());
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver back-pressure, with an optional long hold-off
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_cycles > 0) begin
				out_stall <= 1'b1;
				hold_cycles <= hold_cycles - 1;
			end else begin
				out_stall <= ($urandom_range(99, 0) < recv_idle_pct);
			end
		end
	end

	// Monitor: compare each output transaction with the oldest expectation
	always @(posedge clk) begin
		tilt_t e;
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet <= 0;
			else
				quiet <= quiet + 1;
			if (out_valid && !out_stall) begin
				if (angle_q.size() == 0) begin
					$display("%0t: unexpected transaction pitch %0d roll %0d", $time,
						pitch_angle, roll_angle);
					errors <= errors + 1;
				end else begin
					e = angle_q.pop_front();
					n_checked <= n_checked + 1;
					if (e.pitch_bad || e.roll_bad)
						n_bad_flags <= n_bad_flags + 1;
					if (e.pitch !== pitch_angle || e.roll !== roll_angle ||
							e.pitch_bad !== pitch_invalid || e.roll_bad !== roll_invalid) begin
						$display("%0t: mismatch expected p=%0d r=%0d pi=%0b ri=%0b actual p=%0d r=%0d pi=%0b ri=%0b",
							$time, e.pitch, e.roll, e.pitch_bad, e.roll_bad,
							pitch_angle, roll_angle, pitch_invalid, roll_invalid);
						errors <= errors + 1;
					end
				end
			end
			if (quiet >= WATCHDOG) begin
				$display("%0t: watchdog expired, %0d transactions outstanding", $time,
					angle_q.size());
				$display("accelerometer_tilt_angles verification failed");
				$finish;
			end
		end
	end

	function automatic logic signed [SB-1:0] rand_axis();
		case ($urandom_range(5, 0))
			0: return 16'sh8000;
			1: return 16'sh7FFF;
			2: return SB'($urandom_range(8, 0)) - 16'sd4;
			3: return 16'sd0;
			default: return SB'($urandom);
		endcase
	endfunction

	task automatic queue_sample(logic signed [SB-1:0] x, logic signed [SB-1:0] y,
			logic signed [SB-1:0] z);
		sample_q.push_back('{x: x, y: y, z: z});
	endtask

	// Let the pipeline drain fully before a register write
	task automatic wait_drained();
		wait (sample_q.size() == 0 && angle_q.size() == 0);
		repeat (PIPE_WAIT) @(posedge clk);
	endtask

	task automatic write_orient(logic [1:0] o);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= o;
		orient <= o;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic random_phase(int count, int s_pct, int r_pct);
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		for (int i = 0; i < count; i++)
			queue_sample(rand_axis(), rand_axis(), rand_axis());
		wait_drained();
	endtask

	initial begin
		arst_n <= 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: reset orientation, extremes and zero denominators
		queue_sample(16'sd0, 16'sd0, 16'sd0);
		queue_sample(16'sd0, 16'sd0, 16'sd1000);
		queue_sample(16'sd1000, 16'sd0, 16'sd0);
		queue_sample(16'sd0, 16'sd1000, 16'sd0);
		queue_sample(16'sh8000, 16'sh8000, 16'sh8000);
		queue_sample(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
		queue_sample(16'sh8000, 16'sh7FFF, 16'sd0);
		queue_sample(16'sh7FFF, 16'sh8000, 16'sd1);
		queue_sample(-16'sd1, 16'sd1, -16'sd1);
		queue_sample(16'sd1, 16'sd0, 16'sh8000);
		wait_drained();

		// Directed: each orientation with negated most-negative samples
		for (int o = 0; o < 4; o++) begin
			write_orient(2'(o));
			queue_sample(16'sh8000, 16'sd5, 16'sd0);
			queue_sample(16'sd5, 16'sh8000, 16'sd0);
			queue_sample(16'sd0, 16'sd0, 16'sd0);
			wait_drained();
		end

		// Random phases across orientations and idle profiles
		write_orient(ORIENT_0);
		random_phase(200, 19, 83);
		write_orient(ORIENT_270);
		random_phase(200, 83, 19);
		write_orient(ORIENT_180);
		// long receiver hold-off while the sender keeps offering
		hold_cycles = 300;
		random_phase(400, 0, 0);
		write_orient(ORIENT_90);
		random_phase(400, 0, 0);

		$display("Sent %0d and checked %0d transactions (%0d with an invalid flag),",
			n_sent, n_checked, n_bad_flags);
		$display("over all orientations with sender gaps, receiver stalls and a full-pipeline hold-off.");
		if (errors == 0)
			$display("accelerometer_tilt_angles verification clean");
		else
			$display("accelerometer_tilt_angles verification failed");
		$finish;
	end

endmodule

### accelerometer_tilt_angles.f
src/atilt_pkg.sv
src/atilt_lane.sv
src/accelerometer_tilt_angles.sv
tb/tb_accelerometer_tilt_angles.sv
